### src/pec_pkg.sv
`timescale 1ns / 1ps

package pec_pkg;

    // Sizing
    localparam int MAX_DIMS    = 4;
    localparam int INDEX_BITS  = 24;
    localparam int NUM_COORDS  = 4;
    localparam int COORD_BITS  = 24;
    localparam int STRIDE_BITS = 24;
    localparam int VALUE_BITS  = 32;
    localparam int ETYPE_BITS  = 2;
    localparam int NDIMS_BITS  = 3;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = STRIDE_BITS;

    // Dimensions actually served and the counters that walk them
    localparam int ACTIVE_DIMS  = (MAX_DIMS < NUM_COORDS) ? MAX_DIMS : NUM_COORDS;
    localparam int DIM_BITS     = (NUM_COORDS > 1) ? $clog2(NUM_COORDS) : 1;
    localparam int DIM_CNT_BITS = $clog2(NUM_COORDS + 1);

    // Divider datapath covers both the index and the stride
    localparam int WORK_BITS = (INDEX_BITS > STRIDE_BITS) ? INDEX_BITS : STRIDE_BITS;
    localparam int STEP_BITS = $clog2(WORK_BITS + 1);

    // Element types
    typedef enum logic [ETYPE_BITS-1:0] {
        TYPE_FLOAT32 = 2'd0,
        TYPE_INT32   = 2'd1,
        TYPE_UINT8   = 2'd2
    } elem_type_e;

    // Configuration register map
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_ELEMENT_TYPE = 3'd0,
        REG_NUM_DIMS     = 3'd1,
        REG_STRIDE_0     = 3'd2,
        REG_STRIDE_1     = 3'd3,
        REG_STRIDE_2     = 3'd4,
        REG_STRIDE_3     = 3'd5
    } cfg_reg_e;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic                  last;
    } in_item_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] coord_0;
        logic [COORD_BITS-1:0] coord_1;
        logic [COORD_BITS-1:0] coord_2;
        logic [COORD_BITS-1:0] coord_3;
    } out_item_t;

    // Divider handshake and result
    typedef struct packed {
        logic                 start;
        logic [WORK_BITS-1:0] dividend;
        logic [WORK_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [WORK_BITS-1:0] quotient;
        logic [WORK_BITS-1:0] remainder;
    } div_rsp_t;

endpackage

### src/pec_div.sv
`timescale 1ns / 1ps

// Restoring divider: one quotient bit per cycle, MSB first.
module pec_div
    import pec_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg,    busy_next;
    logic                 done_reg,    done_next;
    logic [STEP_BITS-1:0] cnt_reg,     cnt_next;
    logic [WORK_BITS-1:0] rem_reg,     rem_next;
    logic [WORK_BITS-1:0] quo_reg,     quo_next;
    logic [WORK_BITS-1:0] divisor_reg, divisor_next;

    logic [WORK_BITS:0] partial;
    logic [WORK_BITS:0] diff;

    // Shift in the next dividend bit and try a subtract
    assign partial = {rem_reg, quo_reg[WORK_BITS-1]};
    assign diff    = partial - {1'b0, divisor_reg};

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        divisor_next = divisor_reg;
        if (req.start)
        begin
            busy_next    = 1'b1;
            cnt_next     = STEP_BITS'(WORK_BITS);
            rem_next     = '0;
            quo_next     = req.dividend;
            divisor_next = req.divisor;
        end
        else if (busy_reg)
        begin
            // keep the trial difference only when it did not borrow
            rem_next = diff[WORK_BITS] ? partial[WORK_BITS-1:0] : diff[WORK_BITS-1:0];
            quo_next = {quo_reg[WORK_BITS-2:0], ~diff[WORK_BITS]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == STEP_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        divisor_reg <= divisor_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

### src/positive_element_coordinates.sv
`timescale 1ns / 1ps

// Channel   Direction  Beat content                  Handshake
// in        input      in_item_t  (value, last)      in_valid / in_ready
// out       output     out_item_t (coord_0..3)       out_valid / out_ready
// cfg       input      register index + write data   cfg_valid / cfg_ready (always ready)
//
// An element that is not positive is taken in S_IDLE; the next beat may follow at once.
// A positive element walks the dimensions in turn: one with a non-zero stride runs the
// single bit-serial divider shared by all dimensions, and one with a zero stride takes
// the remainder as its coordinate directly.
// Reset clears the flat index, restores the register defaults and empties the output.
// A finished result sits in the output register while the next element is taken; the
// walk stalls before loading only if the previous result has not yet been taken.
module positive_element_coordinates
    import pec_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  in_item_t                 in_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output out_item_t                out_data,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,      // waiting for an element beat
        S_WORK,      // pick the next dimension, or finish
        S_WAIT_DIV,  // divider running for the current dimension
        S_DONE       // hand the coordinates to the output register
    } state_e;

    typedef logic [COORD_BITS-1:0] coord_t;

    // Configuration
    logic [ETYPE_BITS-1:0]  etype_reg;
    logic [NDIMS_BITS-1:0]  ndims_reg;
    logic [STRIDE_BITS-1:0] stride_reg [NUM_COORDS];

    // Walk state
    state_e                  state_reg,  state_next;
    logic [INDEX_BITS-1:0]   index_reg,  index_next;
    logic [INDEX_BITS-1:0]   rem_reg,    rem_next;
    logic [DIM_CNT_BITS-1:0] dim_reg,    dim_next;
    logic [DIM_CNT_BITS-1:0] dims_reg,   dims_next;
    coord_t                  coord_reg  [NUM_COORDS];
    coord_t                  coord_next [NUM_COORDS];
    logic                    out_valid_reg, out_valid_next;
    out_item_t               out_data_reg,  out_data_next;

    logic                   in_fire;
    logic                   positive;
    logic [DIM_BITS-1:0]    dim_sel;
    logic [STRIDE_BITS-1:0] cur_stride;
    div_req_t               div_req;
    div_rsp_t               div_rsp;

    function automatic logic is_positive(input logic [ETYPE_BITS-1:0] et,
                                         input logic [VALUE_BITS-1:0] v);
        logic res;
        res = 1'b0;
        case (et)
            TYPE_FLOAT32: res = (v != '0) && !v[31] && (v[30:0] <= 31'h7F80_0000);
            TYPE_INT32:   res = (v != '0) && !v[31];
            TYPE_UINT8:   res = (v[7:0] != 8'd0);
            default:      res = 1'b0;
        endcase
        return res;
    endfunction

    assign in_ready   = (state_reg == S_IDLE);
    assign in_fire    = in_valid && in_ready;
    assign positive   = is_positive(etype_reg, in_data.value);
    assign dim_sel    = dim_reg[DIM_BITS-1:0];
    assign cur_stride = stride_reg[dim_sel];
    assign cfg_ready  = 1'b1;

    // Configuration writes; indexes beyond the map are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            etype_reg <= TYPE_FLOAT32;
            ndims_reg <= NDIMS_BITS'(1);
            for (int i = 0; i < NUM_COORDS; i++)
            begin
                stride_reg[i] <= STRIDE_BITS'(1);
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_e'(cfg_index))
                REG_ELEMENT_TYPE: etype_reg     <= cfg_data[ETYPE_BITS-1:0];
                REG_NUM_DIMS:     ndims_reg     <= cfg_data[NDIMS_BITS-1:0];
                REG_STRIDE_0:     stride_reg[0] <= cfg_data[STRIDE_BITS-1:0];
                REG_STRIDE_1:     stride_reg[1] <= cfg_data[STRIDE_BITS-1:0];
                REG_STRIDE_2:     stride_reg[2] <= cfg_data[STRIDE_BITS-1:0];
                REG_STRIDE_3:     stride_reg[3] <= cfg_data[STRIDE_BITS-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        index_next     = index_reg;
        rem_next       = rem_reg;
        dim_next       = dim_reg;
        dims_next      = dims_reg;
        coord_next     = coord_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        div_req.start    = 1'b0;
        div_req.dividend = WORK_BITS'(rem_reg);
        div_req.divisor  = WORK_BITS'(cur_stride);

        // Drop the result once the sink takes it
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    // Advance the flat index, saturating; a last beat rewinds it
                    if (in_data.last)
                    begin
                        index_next = '0;
                    end
                    else if (index_reg != '1)
                    begin
                        index_next = index_reg + 1'b1;
                    end
                    if (positive)
                    begin
                        rem_next = index_reg;
                        dim_next = '0;
                        for (int i = 0; i < NUM_COORDS; i++)
                        begin
                            coord_next[i] = '0;
                        end
                        if (int'(ndims_reg) > ACTIVE_DIMS)
                        begin
                            dims_next = DIM_CNT_BITS'(ACTIVE_DIMS);
                        end
                        else
                        begin
                            dims_next = DIM_CNT_BITS'(ndims_reg);
                        end
                        state_next = S_WORK;
                    end
                end
            end
            S_WORK:
            begin
                if (dim_reg >= dims_reg)
                begin
                    state_next = S_DONE;
                end
                else if (cur_stride == '0)
                begin
                    // Zero stride: the remainder is the coordinate and stays as it is
                    coord_next[dim_sel] = COORD_BITS'(rem_reg);
                    dim_next            = dim_reg + 1'b1;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = S_WAIT_DIV;
                end
            end
            S_WAIT_DIV:
            begin
                if (div_rsp.done)
                begin
                    coord_next[dim_sel] = COORD_BITS'(div_rsp.quotient);
                    rem_next            = INDEX_BITS'(div_rsp.remainder);
                    dim_next            = dim_reg + 1'b1;
                    state_next          = S_WORK;
                end
            end
            S_DONE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next        = 1'b1;
                    out_data_next.coord_0 = coord_reg[0];
                    out_data_next.coord_1 = coord_reg[1];
                    out_data_next.coord_2 = coord_reg[2];
                    out_data_next.coord_3 = coord_reg[3];
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            index_reg     <= '0;
            dim_reg       <= '0;
            dims_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            index_reg     <= index_next;
            dim_reg       <= dim_next;
            dims_reg      <= dims_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg      <= rem_next;
        coord_reg    <= coord_next;
        out_data_reg <= out_data_next;
    end

    pec_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### src/pec_checker.sv
`timescale 1ns / 1ps

module pec_checker
    import pec_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    // A stalled result beat holds its coordinates
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // Output is empty while in reset
    assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result beat shown during reset");

    // A result never appears in the cycle straight after an element is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared without coordinate walk");

    // Element input is closed while a coordinate walk is running after a take
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result loaded while element input was open");

endmodule

bind positive_element_coordinates pec_checker u_pec_checker (.*);
